// File: hdl/cache_way_replacement_policy_assert.svh
// Assertion macros shared by the replacement engine.
// Every check samples on the rising edge of clk and is off while rst is high.
`ifndef CACHE_WAY_REPLACEMENT_POLICY_ASSERT_SVH
`define CACHE_WAY_REPLACEMENT_POLICY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("replacement engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define CWRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("replacement engine check failed");

`endif

// File: hdl/cwrp_pkg.sv
package cwrp_pkg;

  // Replacement policy codes; the unused code falls back to first-in first-out.
  localparam logic [1:0] POLICY_FIFO = 2'd0;
  localparam logic [1:0] POLICY_LRU  = 2'd1;
  localparam logic [1:0] POLICY_LFU  = 2'd2;

  // Access kinds carried in the input tuser bit.
  localparam logic MODE_HIT  = 1'b0;
  localparam logic MODE_FILL = 1'b1;

  // Fixed field widths of the stream items.
  localparam int SET_W      = 6;
  localparam int WAY_W      = 2;
  localparam int TAG_W      = 32;
  localparam int PID_W      = 16;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

endpackage

// File: hdl/cwrp_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module cwrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in the same cycle return the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/cache_way_replacement_policy.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one hit-touch or miss-fill item
// m_axis    out        m_axis_tvalid / m_axis_tready  chosen way and evicted line
// cfg       in         cfg_valid / cfg_ready          replacement policy register
//
// One item enters every cycle unless the output stalls; it moves to stage one, then to
// the output register. The set's row is read from RAM in the accept cycle, written as
// the item leaves stage one, and forwarded, so same-set items may follow directly.
// Reset clears one valid flag per set row at once; no clearing pass is needed.
// A stalled output holds the result and the item behind it; input stalls only then.
`include "cache_way_replacement_policy_assert.svh"

module cache_way_replacement_policy
  import cwrp_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int TAG_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: set(6), way(2), tag(32), pid(16), write(1), zeros.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: mode(1).
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: chosen_way(2), evicted_valid(1), evicted_dirty(1),
  // evicted_tag(32), evicted_owner(16), zeros.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_data
);

  localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_PAD  = 1 << WAY_BITS;
  localparam logic [WAY_BITS-1:0] RANK_MAX = WAY_BITS'(WAYS - 1);

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [WAY_BITS-1:0]   rank;
    logic [COUNT_BITS-1:0] count;
  } meta_way_t;

  typedef struct packed {
    meta_way_t [WAYS-1:0] ways;
    logic [WAY_BITS-1:0]  ptr;
  } meta_row_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [PID_W-1:0]    owner;
  } data_way_t;

  typedef data_way_t [WAYS-1:0] data_row_t;

  // Input field unpacking.
  logic [SET_W-1:0] in_set;
  logic [WAY_W-1:0] in_way;
  logic [TAG_W-1:0] in_tag;
  logic [PID_W-1:0] in_pid;
  logic             in_write;
  logic [SET_BITS+SET_W-1:0] in_set_ext;
  logic [WAY_BITS+WAY_W-1:0] in_way_ext;
  logic [63:0]               in_tag_wide;

  assign in_set      = s_axis_tdata[5:0];
  assign in_way      = s_axis_tdata[7:6];
  assign in_tag      = s_axis_tdata[39:8];
  assign in_pid      = s_axis_tdata[55:40];
  assign in_write    = s_axis_tdata[56];
  assign in_set_ext  = (SET_BITS + SET_W)'(in_set);
  assign in_way_ext  = (WAY_BITS + WAY_W)'(in_way);
  assign in_tag_wide = 64'(in_tag);

  // Handshake and flow control.
  logic accept;
  logic s1_valid;
  logic s1_advance;

  assign s1_advance    = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Policy register.
  logic [1:0] replacement_policy;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_policy <= POLICY_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      replacement_policy <= cfg_data;
    end
  end

  // Stage one item register.
  logic                s1_mode;
  logic                s1_ignore;
  logic [SET_BITS-1:0] s1_set;
  logic [WAY_BITS-1:0] s1_way;
  logic [TAG_BITS-1:0] s1_tag;
  logic [PID_W-1:0]    s1_pid;
  logic                s1_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= s_axis_tuser;
      s1_ignore <= (int'(in_set) >= SETS) ||
                   ((s_axis_tuser == MODE_HIT) && (int'(in_way) >= WAYS));
      s1_set    <= in_set_ext[SET_BITS-1:0];
      s1_way    <= in_way_ext[WAY_BITS-1:0];
      s1_tag    <= in_tag_wide[TAG_BITS-1:0];
      s1_pid    <= in_pid;
      s1_write  <= in_write;
    end
  end

  // Metadata and line data memories, one row per set.
  logic      wr_en;
  meta_row_t meta_ram_q;
  data_row_t data_ram_q;
  meta_row_t meta_next;
  data_row_t data_next;

  cwrp_ram #(
    .WIDTH ($bits(meta_row_t)),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_set),
    .wr_data (meta_next),
    .rd_en   (accept),
    .rd_addr (in_set_ext[SET_BITS-1:0]),
    .rd_data (meta_ram_q)
  );

  cwrp_ram #(
    .WIDTH ($bits(data_row_t)),
    .DEPTH (SETS)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_set),
    .wr_data (data_next),
    .rd_en   (accept),
    .rd_addr (in_set_ext[SET_BITS-1:0]),
    .rd_data (data_ram_q)
  );

  // Row valid flags, and the last row written for same-set items back to back.
  logic [SETS-1:0]     row_valid;
  logic                fwd_valid;
  logic [SET_BITS-1:0] fwd_set;
  meta_row_t           fwd_meta;
  data_row_t           fwd_data;

  assign wr_en = s1_advance && !s1_ignore;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      row_valid[s1_set] <= 1'b1;
      fwd_valid         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_set  <= s1_set;
      fwd_meta <= meta_next;
      fwd_data <= data_next;
    end
  end

  // Current view of the set: forwarded row, stored row, or for metadata the reset row.
  logic      fwd_hit;
  meta_row_t meta_cur;
  data_row_t data_cur;

  assign fwd_hit  = fwd_valid && (fwd_set == s1_set);
  assign meta_cur = fwd_hit ? fwd_meta : (row_valid[s1_set] ? meta_ram_q : '0);
  assign data_cur = fwd_hit ? fwd_data : data_ram_q;

  // Least-used and oldest ways, found by pairwise trees where the lower index wins ties.
  logic [COUNT_BITS-1:0] cnt_node [WAY_BITS+1][WAY_PAD];
  logic [WAY_BITS-1:0]   cnt_idx  [WAY_BITS+1][WAY_PAD];
  logic [WAY_BITS-1:0]   rnk_node [WAY_BITS+1][WAY_PAD];
  logic [WAY_BITS-1:0]   rnk_idx  [WAY_BITS+1][WAY_PAD];
  logic [WAY_BITS-1:0]   lfu_way;
  logic [WAY_BITS-1:0]   lru_way;

  always_comb begin
    for (int l = 0; l <= WAY_BITS; l++) begin
      for (int i = 0; i < WAY_PAD; i++) begin
        cnt_node[l][i] = '1;
        cnt_idx[l][i]  = '0;
        rnk_node[l][i] = '0;
        rnk_idx[l][i]  = '0;
      end
    end
    for (int i = 0; i < WAY_PAD; i++) begin
      cnt_idx[0][i] = WAY_BITS'(i);
      rnk_idx[0][i] = WAY_BITS'(i);
      if (i < WAYS) begin
        cnt_node[0][i] = meta_cur.ways[i].count;
        rnk_node[0][i] = meta_cur.ways[i].rank;
      end
    end
    for (int l = 0; l < WAY_BITS; l++) begin
      for (int i = 0; i < (WAY_PAD >> (l + 1)); i++) begin
        if (cnt_node[l][2*i+1] < cnt_node[l][2*i]) begin
          cnt_node[l+1][i] = cnt_node[l][2*i+1];
          cnt_idx[l+1][i]  = cnt_idx[l][2*i+1];
        end else begin
          cnt_node[l+1][i] = cnt_node[l][2*i];
          cnt_idx[l+1][i]  = cnt_idx[l][2*i];
        end
        if (rnk_node[l][2*i+1] > rnk_node[l][2*i]) begin
          rnk_node[l+1][i] = rnk_node[l][2*i+1];
          rnk_idx[l+1][i]  = rnk_idx[l][2*i+1];
        end else begin
          rnk_node[l+1][i] = rnk_node[l][2*i];
          rnk_idx[l+1][i]  = rnk_idx[l][2*i];
        end
      end
    end
    lfu_way = cnt_idx[WAY_BITS][0];
    lru_way = rnk_idx[WAY_BITS][0];
  end

  // Victim choice: lowest invalid way first, otherwise by policy.
  logic [WAYS-1:0]     valid_vec;
  logic                set_full;
  logic [WAY_BITS-1:0] first_invalid;
  logic [WAY_BITS-1:0] victim;
  logic                fifo_victim;

  always_comb begin
    first_invalid = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      valid_vec[i] = meta_cur.ways[i].valid;
      if (!meta_cur.ways[i].valid) begin
        first_invalid = WAY_BITS'(i);
      end
    end
    set_full    = &valid_vec;
    fifo_victim = 1'b0;
    if (!set_full) begin
      victim = first_invalid;
    end else begin
      case (replacement_policy)
        POLICY_LRU: victim = lru_way;
        POLICY_LFU: victim = lfu_way;
        default: begin
          victim      = meta_cur.ptr;
          fifo_victim = 1'b1;
        end
      endcase
    end
  end

  // Row update and result for the item in stage one.
  logic [WAY_BITS-1:0]   way_sel;
  logic [WAY_BITS-1:0]   old_rank;
  logic [WAY_BITS+1:0]   way_sel_ext;
  logic [63:0]           ev_tag_wide;
  logic [1:0]            res_way;
  logic                  res_ev_valid;
  logic                  res_ev_dirty;
  logic [TAG_W-1:0]      res_ev_tag;
  logic [PID_W-1:0]      res_ev_owner;

  assign way_sel     = (s1_mode == MODE_FILL) ? victim : s1_way;
  assign old_rank    = meta_cur.ways[way_sel].rank;
  assign way_sel_ext = (WAY_BITS + 2)'(way_sel);
  assign ev_tag_wide = 64'(data_cur[way_sel].tag);

  always_comb begin
    meta_next = meta_cur;
    data_next = data_cur;
    for (int i = 0; i < WAYS; i++) begin
      if ((WAY_BITS'(i) != way_sel) && (meta_cur.ways[i].rank <= old_rank) &&
          (meta_cur.ways[i].rank < RANK_MAX)) begin
        meta_next.ways[i].rank = meta_cur.ways[i].rank + WAY_BITS'(1);
      end
    end
    meta_next.ways[way_sel].rank = '0;
    if (s1_mode == MODE_FILL) begin
      meta_next.ways[way_sel].valid = 1'b1;
      meta_next.ways[way_sel].dirty = s1_write;
      meta_next.ways[way_sel].count = COUNT_BITS'(1);
      data_next[way_sel].tag        = s1_tag;
      data_next[way_sel].owner      = s1_pid;
      if (fifo_victim) begin
        meta_next.ptr = (meta_cur.ptr == RANK_MAX) ? '0 : meta_cur.ptr + WAY_BITS'(1);
      end
    end else if (meta_cur.ways[way_sel].count != '1) begin
      meta_next.ways[way_sel].count = meta_cur.ways[way_sel].count + COUNT_BITS'(1);
    end
  end

  always_comb begin
    res_way      = '0;
    res_ev_valid = 1'b0;
    res_ev_dirty = 1'b0;
    res_ev_tag   = '0;
    res_ev_owner = '0;
    if (!s1_ignore) begin
      res_way = way_sel_ext[1:0];
      if ((s1_mode == MODE_FILL) && meta_cur.ways[way_sel].valid) begin
        res_ev_valid = 1'b1;
        res_ev_dirty = meta_cur.ways[way_sel].dirty;
        res_ev_tag   = ev_tag_wide[TAG_W-1:0];
        res_ev_owner = data_cur[way_sel].owner;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_axis_tdata <= {4'b0, res_ev_owner, res_ev_tag, res_ev_dirty, res_ev_valid, res_way};
    end
  end

  // An ignored item leaves an all-zero result.
  `CWRP_ASSERT_NEXT(a_ignored_zero, s1_advance && s1_ignore, m_axis_tdata == '0)
  // A hit never reports an eviction.
  `CWRP_ASSERT_NEXT(a_hit_no_evict, s1_advance && (s1_mode == MODE_HIT),
                    !m_axis_tdata[2])
  // A fill into a set with a free way never replaces a valid line.
  `CWRP_ASSERT_SAME(a_free_way_first,
                    s1_valid && !s1_ignore && (s1_mode == MODE_FILL) && !set_full,
                    !meta_cur.ways[way_sel].valid)
  // After a fill commits, the forwarded row holds the filled way as valid.
  `CWRP_ASSERT_NEXT(a_fill_forwarded, wr_en && (s1_mode == MODE_FILL),
                    fwd_valid && (fwd_set == $past(s1_set)) &&
                    fwd_meta.ways[$past(way_sel)].valid)

endmodule
